// File: rtl/cctm_pkg.sv
// ----------------------------------------------------------------------------
// cctm_pkg: shared types and constants of the chunk chain table manager
// Holds the table geometry, operation and status codes, and the command and
// status structs that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none
package cctm_pkg;

  localparam int TableDepth = 4096;
  localparam int AddrW      = $clog2(TableDepth);
  localparam int LinkW      = 12;
  localparam int TypeW      = 4;
  localparam int CountW     = 12;
  localparam int StatusW    = 3;
  localparam int OpW        = 3;
  localparam logic [TypeW-1:0] HeadTypeMin = 4'd8;

  localparam logic [OpW-1:0] OP_ALLOC   = 3'd0;
  localparam logic [OpW-1:0] OP_FREE    = 3'd1;
  localparam logic [OpW-1:0] OP_MEASURE = 3'd2;
  localparam logic [OpW-1:0] OP_READ    = 3'd3;
  localparam logic [OpW-1:0] OP_WRITE   = 3'd4;

  localparam logic [StatusW-1:0] ST_OK      = 3'd0;
  localparam logic [StatusW-1:0] ST_BAD     = 3'd1;
  localparam logic [StatusW-1:0] ST_SPACE   = 3'd2;
  localparam logic [StatusW-1:0] ST_BROKEN  = 3'd3;
  localparam logic [StatusW-1:0] ST_NOTHEAD = 3'd4;
  localparam logic [StatusW-1:0] ST_LOOP    = 3'd5;

  localparam logic CFG_UNUSED = 1'b0;
  localparam logic CFG_CONT   = 1'b1;

  // Memory access command from the controller.
  typedef struct packed {
    logic             rd_en;
    logic [LinkW-1:0] rd_addr;
    logic             wr_en;
    logic [LinkW-1:0] wr_addr;
    logic [TypeW-1:0] wr_type;
    logic [LinkW-1:0] wr_link;
  } mem_cmd_t;

  // Registered read data back to the controller.
  typedef struct packed {
    logic [TypeW-1:0] rd_type;
    logic [LinkW-1:0] rd_link;
  } mem_stat_t;

  function automatic logic in_range(input logic [LinkW-1:0] a);
    return ({1'b0, a} < 13'(TableDepth));
  endfunction

endpackage : cctm_pkg
`default_nettype wire

// File: rtl/cctm_table.sv
// ----------------------------------------------------------------------------
// cctm_table: chunk table datapath
// One-write, one-read memory of type and link fields with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module cctm_table (
  input  wire logic               clk,
  input  wire cctm_pkg::mem_cmd_t cmd,
  output cctm_pkg::mem_stat_t     stat
);
  import cctm_pkg::*;

  logic [TypeW+LinkW-1:0] mem [TableDepth];
  logic [TypeW+LinkW-1:0] rdata;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_addr[AddrW-1:0]] <= {cmd.wr_type, cmd.wr_link};
    end
    if (cmd.rd_en) begin
      rdata <= mem[cmd.rd_addr[AddrW-1:0]];
    end
  end

  assign stat.rd_type = rdata[TypeW+LinkW-1:LinkW];
  assign stat.rd_link = rdata[LinkW-1:0];

endmodule : cctm_table
`default_nettype wire

// File: rtl/cctm_ctrl.sv
// ----------------------------------------------------------------------------
// cctm_ctrl: chunk chain controller
// Sequences the check walks and write passes of each operation over the table.
// ----------------------------------------------------------------------------
`default_nettype none
module cctm_ctrl (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [cctm_pkg::OpW-1:0]       op,
  input  wire logic [cctm_pkg::LinkW-1:0]     slot_index,
  input  wire logic [cctm_pkg::CountW-1:0]    slot_count,
  input  wire logic [cctm_pkg::TypeW-1:0]     type_value,
  input  wire logic [cctm_pkg::LinkW-1:0]     link_value,
  input  wire logic [cctm_pkg::TypeW-1:0]     unused_code,
  input  wire logic [cctm_pkg::TypeW-1:0]     cont_code,
  output cctm_pkg::mem_cmd_t                  cmd,
  input  wire cctm_pkg::mem_stat_t            stat,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [cctm_pkg::StatusW-1:0]        status,
  output logic [cctm_pkg::LinkW-1:0]          slot_out,
  output logic [cctm_pkg::TypeW-1:0]          type_out,
  output logic [cctm_pkg::CountW-1:0]         chain_length
);
  import cctm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_READ, S_ACHK, S_AWR, S_AFIN,
    S_FCHK, S_FHEAD, S_FWR, S_MHEAD, S_MWALK, S_DONE
  } state_t;

  state_t           state;
  logic [OpW-1:0]   r_op;
  logic [LinkW-1:0] r_idx;
  logic [CountW-1:0] r_cnt;
  logic [TypeW-1:0] r_type;
  logic [LinkW-1:0] r_link;
  logic [CountW-1:0] step;
  logic [LinkW-1:0] cur;
  logic [LinkW-1:0] old_head;
  logic [TypeW-1:0] head_type;
  logic [LinkW-1:0] first_slot;
  logic             bad_req;

  assign in_stall = (state != S_IDLE);

  // First slot taken by an alloc: on the first check step it is the link of
  // entry 0 now in the read data, later it has been kept in slot_out.
  assign first_slot = (step == '0) ? stat.rd_link : slot_out;

  always_comb begin
    case (op)
      OP_ALLOC:            bad_req = (slot_count == '0);
      OP_FREE, OP_MEASURE: bad_req = (slot_index == '0) || !in_range(slot_index);
      OP_READ, OP_WRITE:   bad_req = !in_range(slot_index);
      default:             bad_req = 1'b1;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      S_DISPATCH: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = (r_op == OP_ALLOC) ? '0 : r_idx;
        if (r_op == OP_WRITE && in_range(r_idx)) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_addr = r_idx;
          cmd.wr_type = r_type;
          cmd.wr_link = r_link;
          cmd.rd_en   = 1'b0;
        end
      end
      S_ACHK: begin
        // The last check step fetches the first taken slot for the write pass.
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = (step == r_cnt - 1'b1) ? first_slot : stat.rd_link;
      end
      S_FCHK, S_MWALK, S_MHEAD: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = stat.rd_link;
      end
      S_AWR: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = stat.rd_link;
        cmd.wr_en   = 1'b1;
        cmd.wr_addr = cur;
        cmd.wr_type = (step == '0) ? r_type : cont_code;
        cmd.wr_link = (step == r_cnt - 1'b1) ? '0 : stat.rd_link;
      end
      S_AFIN: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_addr = '0;
        cmd.wr_type = head_type;
        cmd.wr_link = cur;
      end
      S_FHEAD: begin
        // Entry 0 is in the read data here; keep its type.
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = r_idx;
        cmd.wr_en   = 1'b1;
        cmd.wr_addr = '0;
        cmd.wr_type = stat.rd_type;
        cmd.wr_link = r_idx;
      end
      S_FWR: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = stat.rd_link;
        cmd.wr_en   = 1'b1;
        cmd.wr_addr = cur;
        cmd.wr_type = unused_code;
        cmd.wr_link = (stat.rd_link == '0) ? old_head : stat.rd_link;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            r_op   <= op;
            r_idx  <= slot_index;
            r_cnt  <= slot_count;
            r_type <= type_value;
            r_link <= link_value;
            step   <= '0;
            cur    <= '0;
            slot_out <= '0;
            type_out <= '0;
            chain_length <= '0;
            if (bad_req) begin
              status <= ST_BAD;
              state  <= S_DONE;
            end else begin
              status <= ST_OK;
              state  <= S_DISPATCH;
            end
          end
        end
        S_DISPATCH: begin
          case (r_op)
            OP_ALLOC:   state <= S_ACHK;
            OP_FREE:    state <= S_FCHK;
            OP_MEASURE: state <= S_MHEAD;
            OP_READ:    state <= S_READ;
            default:    state <= S_DONE;
          endcase
          step <= (r_op == OP_FREE) ? 12'd1 : '0;
        end
        S_READ: begin
          slot_out <= stat.rd_link;
          type_out <= stat.rd_type;
          state    <= S_DONE;
        end
        S_ACHK: begin
          // The entry being checked is in stat; step counts checked entries.
          if (step == '0) head_type <= stat.rd_type;
          if (stat.rd_link == '0) begin
            status <= ST_SPACE; slot_out <= '0; state <= S_DONE;
          end else if (stat.rd_type != unused_code || !in_range(stat.rd_link)) begin
            status <= ST_BROKEN; slot_out <= '0; state <= S_DONE;
          end else begin
            if (step == '0) slot_out <= stat.rd_link;
            if (step == r_cnt - 1'b1) begin
              step  <= '0;
              cur   <= first_slot;
              state <= S_AWR;
            end else begin
              step <= step + 1'b1;
            end
          end
        end
        S_AWR: begin
          // Entry cur is in stat; its link is the next slot to retype.
          cur <= stat.rd_link;
          if (step == r_cnt - 1'b1) begin
            state <= S_AFIN;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_AFIN: state <= S_DONE;
        S_FCHK: begin
          if (stat.rd_link == '0) begin
            state <= S_FHEAD;
          end else if (!in_range(stat.rd_link)) begin
            status <= ST_BROKEN; state <= S_DONE;
          end else if ({1'b0, step} + 13'd1 >= 13'(TableDepth)) begin
            status <= ST_LOOP; state <= S_DONE;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_FHEAD: begin
          old_head <= stat.rd_link;
          cur      <= r_idx;
          state    <= S_FWR;
        end
        S_FWR: begin
          cur <= stat.rd_link;
          if (stat.rd_link == '0) state <= S_DONE;
        end
        S_MHEAD: begin
          head_type <= stat.rd_type;
          step      <= 12'd1;
          if (stat.rd_type < HeadTypeMin) begin
            status <= ST_NOTHEAD; state <= S_DONE;
          end else if (stat.rd_link == '0) begin
            type_out <= stat.rd_type; chain_length <= 12'd1; state <= S_DONE;
          end else if (!in_range(stat.rd_link)) begin
            status <= ST_BROKEN; state <= S_DONE;
          end else begin
            state <= S_MWALK;
          end
        end
        S_MWALK: begin
          if (stat.rd_type != cont_code) begin
            status <= ST_BROKEN; state <= S_DONE;
          end else if ({1'b0, step} + 13'd1 >= 13'(TableDepth)) begin
            status <= ST_LOOP; state <= S_DONE;
          end else if (stat.rd_link == '0) begin
            type_out <= head_type; chain_length <= step + 1'b1; state <= S_DONE;
          end else if (!in_range(stat.rd_link)) begin
            status <= ST_BROKEN; state <= S_DONE;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_DONE: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
          end else if (!out_stall) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  property p_no_write_idle;
    @(posedge clk) disable iff (rst) (state == S_IDLE) |-> !cmd.wr_en;
  endproperty
  a_no_write_idle: assert property (p_no_write_idle) else $error("write while idle");

  property p_out_done;
    @(posedge clk) disable iff (rst) out_valid |-> (state == S_DONE);
  endproperty
  a_out_done: assert property (p_out_done) else $error("result outside done");

  property p_bad_clears;
    @(posedge clk) disable iff (rst) (out_valid && status != ST_OK) |->
      (slot_out == '0 && chain_length == '0);
  endproperty
  a_bad_clears: assert property (p_bad_clears) else $error("fields set on error");

endmodule : cctm_ctrl
`default_nettype wire

// File: rtl/chunk_chain_table_manager_unit.sv
// ----------------------------------------------------------------------------
// chunk_chain_table_manager_unit: linked free-list chunk allocator
// Top level joining the configuration registers, controller and chunk table.
// ----------------------------------------------------------------------------
// The block keeps a 4096-entry table of chunks (4-bit type, 12-bit link);
// entry 0 heads the free list and a link of 0 ends a chain. It takes one
// transaction at a time and returns exactly one result transaction per item.
// Every operation walks the table through a single memory with one read and
// one write port and registered read data, at one entry per cycle. A request
// that fails ends its walk early, and a looping chain stops after about 4096
// steps. The input is taken again in the cycle after the result is handed
// over, and output stall holds the result and delays that. Entries must be
// written before they are read. Configuration writes are taken at any time
// and must only be issued while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none
module chunk_chain_table_manager_unit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [cctm_pkg::OpW-1:0]    op,
  input  wire logic [cctm_pkg::LinkW-1:0]  slot_index,
  input  wire logic [cctm_pkg::CountW-1:0] slot_count,
  input  wire logic [cctm_pkg::TypeW-1:0]  type_value,
  input  wire logic [cctm_pkg::LinkW-1:0]  link_value,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [0:0]                  cfg_index,
  input  wire logic [cctm_pkg::TypeW-1:0]  cfg_data,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [cctm_pkg::StatusW-1:0]     status,
  output logic [cctm_pkg::LinkW-1:0]       slot_out,
  output logic [cctm_pkg::TypeW-1:0]       type_out,
  output logic [cctm_pkg::CountW-1:0]      chain_length
);
  import cctm_pkg::*;

  logic [TypeW-1:0] unused_code;
  logic [TypeW-1:0] cont_code;
  mem_cmd_t         cmd;
  mem_stat_t        stat;

  // Configuration writes are always accepted.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      unused_code <= 4'd0;
      cont_code   <= 4'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_UNUSED: unused_code <= cfg_data;
        CFG_CONT:   cont_code   <= cfg_data;
        default: ;
      endcase
    end
  end

  cctm_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .op, .slot_index, .slot_count,
    .type_value, .link_value, .unused_code, .cont_code, .cmd, .stat,
    .out_valid, .out_stall, .status, .slot_out, .type_out, .chain_length
  );

  cctm_table u_table (.clk, .cmd, .stat);

endmodule : chunk_chain_table_manager_unit
`default_nettype wire

// File: test/tb_chunk_chain_table_manager_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_chunk_chain_table_manager_unit: self-checking test of the chunk allocator
// Drives alloc, free, measure, read and write transactions with random gaps
// and output stalls, predicts every result from a private copy of the chunk
// table, and compares each result field by field in order of arrival.
// ----------------------------------------------------------------------------
`default_nettype none

import cctm_pkg::*;

typedef struct packed {
  logic [OpW-1:0]    op;
  logic [LinkW-1:0]  idx;
  logic [CountW-1:0] cnt;
  logic [TypeW-1:0]  tv;
  logic [LinkW-1:0]  lv;
} chunk_cmd_t;

typedef struct packed {
  logic [StatusW-1:0] status;
  logic [LinkW-1:0]   slot;
  logic [TypeW-1:0]   typ;
  logic [CountW-1:0]  len;
} chunk_result_t;

// Scoreboard: mirrors the chunk table and holds the results still owed.
class chain_table_board;
  logic [15:0]    tbl[TableDepth];
  bit             wr[TableDepth];
  logic [TypeW-1:0] unused_code = 4'd0;
  logic [TypeW-1:0] cont_code   = 4'd1;
  bit             stray;
  chunk_result_t  owed[$];
  int             written[$];
  int             heads[$];
  int             errors;

  // Table reads that are to be checked go through here so stray reads can be detected.
  function logic [TypeW-1:0] typ_of(int i);
    if (!wr[i]) stray = 1;
    return tbl[i][15:12];
  endfunction

  function logic [LinkW-1:0] link_of(int i);
    if (!wr[i]) stray = 1;
    return tbl[i][11:0];
  endfunction

  function chunk_result_t apply(chunk_cmd_t c);
    chunk_result_t r;
    int cur, nxt, n, old;
    r = '0;
    r.status = ST_OK;
    case (c.op)
      OP_ALLOC: begin
        if (c.cnt == 0) r.status = ST_BAD;
        else begin
          cur = 0;
          for (int i = 0; i < c.cnt && r.status == ST_OK; i++) begin
            nxt = link_of(cur);
            if (nxt == 0) r.status = ST_SPACE;
            else if (typ_of(cur) != unused_code) r.status = ST_BROKEN;
            cur = nxt;
          end
          if (r.status == ST_OK) begin
            r.slot = tbl[0][11:0];
            cur = r.slot;
            for (int i = 0; i < c.cnt; i++) begin
              nxt = link_of(cur);
              tbl[cur][15:12] = (i == 0) ? c.tv : cont_code;
              if (i == c.cnt - 1) tbl[cur][11:0] = '0;
              cur = nxt;
            end
            tbl[0][11:0] = cur[11:0];
            heads.push_back(r.slot);
          end
        end
      end
      OP_FREE: begin
        if (c.idx == 0) r.status = ST_BAD;
        else begin
          cur = c.idx;
          n = 0;
          forever begin
            n++;
            if (n >= TableDepth) begin
              r.status = ST_LOOP;
              break;
            end
            nxt = link_of(cur);
            if (nxt == 0) break;
            cur = nxt;
          end
          if (r.status == ST_OK) begin
            old = tbl[0][11:0];
            tbl[0][11:0] = c.idx;
            cur = c.idx;
            forever begin
              nxt = tbl[cur][11:0];
              tbl[cur][15:12] = unused_code;
              if (nxt == 0) begin
                tbl[cur][11:0] = old[11:0];
                break;
              end
              cur = nxt;
            end
          end
        end
      end
      OP_MEASURE: begin
        if (c.idx == 0) r.status = ST_BAD;
        else if (typ_of(c.idx) < HeadTypeMin) r.status = ST_NOTHEAD;
        else begin
          n = 1;
          cur = link_of(c.idx);
          while (cur != 0 && r.status == ST_OK) begin
            if (typ_of(cur) != cont_code) r.status = ST_BROKEN;
            else begin
              n++;
              if (n >= TableDepth) r.status = ST_LOOP;
              cur = link_of(cur);
            end
          end
          if (r.status == ST_OK) begin
            r.typ = tbl[c.idx][15:12];
            r.len = n[11:0];
          end
        end
      end
      OP_READ: begin
        r.slot = link_of(c.idx);
        r.typ  = typ_of(c.idx);
      end
      OP_WRITE: begin
        tbl[c.idx] = {c.tv, c.lv};
        if (!wr[c.idx]) written.push_back(c.idx);
        wr[c.idx] = 1;
      end
      default: r.status = ST_BAD;
    endcase
    if (r.status != ST_OK) r = '{status: r.status, default: '0};
    return r;
  endfunction

  // Runs a command against a scratch copy to see whether it would read an
  // entry that has never been written.
  function bit touches_blank(chunk_cmd_t c);
    logic [15:0] t_save[TableDepth];
    bit w_save[TableDepth];
    int wl_save[$], h_save[$];
    chunk_result_t r;
    t_save = tbl; w_save = wr; wl_save = written; h_save = heads;
    stray = 0;
    r = apply(c);
    tbl = t_save; wr = w_save; written = wl_save; heads = h_save;
    return stray;
  endfunction

  function void note_input(chunk_cmd_t c);
    owed.push_back(apply(c));
  endfunction

  function void check_result(chunk_result_t got);
    chunk_result_t exp;
    if (owed.size() == 0) begin
      $error("unexpected result transaction, status %0d", got.status);
      errors++;
      return;
    end
    exp = owed.pop_front();
    if (got.status != exp.status) begin
      $error("status: expected %0d, got %0d", exp.status, got.status); errors++;
    end
    if (got.slot != exp.slot) begin
      $error("slot_out: expected %0d, got %0d", exp.slot, got.slot); errors++;
    end
    if (got.typ != exp.typ) begin
      $error("type_out: expected %0d, got %0d", exp.typ, got.typ); errors++;
    end
    if (got.len != exp.len) begin
      $error("chain_length: expected %0d, got %0d", exp.len, got.len); errors++;
    end
  endfunction
endclass

module tb_chunk_chain_table_manager_unit;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0, cfg_valid = 0, out_stall = 0;
  logic [OpW-1:0]    op = '0;
  logic [LinkW-1:0]  slot_index = '0, link_value = '0;
  logic [CountW-1:0] slot_count = '0;
  logic [TypeW-1:0]  type_value = '0, cfg_data = '0;
  logic [0:0]        cfg_index = '0;
  logic in_stall, cfg_ready, out_valid;
  logic [StatusW-1:0] status;
  logic [LinkW-1:0]   slot_out;
  logic [TypeW-1:0]   type_out;
  logic [CountW-1:0]  chain_length;

  chain_table_board board = new();
  // When set, neither side inserts gaps, so back-to-back transactions occur.
  bit steady;
  int quiet_cycles;
  int stall_left;

  chunk_chain_table_manager_unit dut (.*);

  initial forever #1 clk = ~clk;

  // Gap lengths: mostly none or short, now and then a long pause.
  function int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // The receiving side: sample results and pick the stall for the next edge.
  // Values read here are the ones from before the edge, since every driver
  // updates with nonblocking assignments. Stalls come in bursts drawn from
  // the same gap lengths as the input side.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      board.check_result('{status, slot_out, type_out, chain_length});
    if (rst || steady) begin
      out_stall  <= 0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall  <= 0;
      stall_left <= gap_len();
    end
  end

  // Watchdog: a long chain walk runs without any transaction, so the limit sits
  // well above the longest walk.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 40000) begin
      $display("tb_chunk_chain_table_manager_unit: errors");
      $finish;
    end
  end

  // One input transaction; the predictor is updated at the accepting edge.
  task automatic send(chunk_cmd_t c);
    int g;
    in_valid <= 1;
    {op, slot_index, slot_count, type_value, link_value} <= c;
    do @(posedge clk); while (in_stall);
    board.note_input(c);
    g = gap_len();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
  endtask

  function automatic chunk_cmd_t mk(logic [OpW-1:0] o, int idx, int cnt = 0,
                                    int tv = 0, int lv = 0);
    return '{o, idx[LinkW-1:0], cnt[CountW-1:0], tv[TypeW-1:0], lv[LinkW-1:0]};
  endfunction

  // Registers are written only once every owed result has come back.
  task automatic drain();
    in_valid <= 0;
    while (board.owed.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Leaves cfg_valid high; the caller drops it after its last write.
  task automatic write_cfg(logic [0:0] idx, logic [TypeW-1:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_UNUSED) board.unused_code = val;
    else board.cont_code = val;
  endtask

  // Lays a fresh free list of 48 scattered slots behind entry 0, typed with
  // the current unused code. Old chains are forgotten.
  task automatic lay_free_list();
    int slots[$];
    bit taken[int];
    int s;
    while (slots.size() < 48) begin
      s = $urandom_range(1, TableDepth - 1);
      if (!taken.exists(s)) begin
        taken[s] = 1;
        slots.push_back(s);
      end
    end
    send(mk(OP_WRITE, 0, 0, board.unused_code, slots[0]));
    for (int i = 0; i < 48; i++)
      send(mk(OP_WRITE, slots[i], 0, board.unused_code, (i == 47) ? 0 : slots[i + 1]));
    board.heads.delete();
  endtask

  function automatic int pick_written();
    return board.written[$urandom_range(0, board.written.size() - 1)];
  endfunction

  function automatic int pick_head();
    int k;
    if (board.heads.size() == 0 || $urandom_range(0, 4) == 0) return pick_written();
    k = $urandom_range(0, board.heads.size() - 1);
    pick_head = board.heads[k];
    board.heads.delete(k);
  endfunction

  // Random command, weighted toward alloc/free/measure of live chains so the
  // table keeps churning; anything that would read a blank entry becomes a
  // write of that entry instead.
  function automatic chunk_cmd_t random_cmd();
    chunk_cmd_t c;
    int r;
    c = mk(OP_WRITE, $urandom_range(0, 4095), $urandom_range(0, 4095),
           $urandom_range(0, 15), $urandom_range(0, 4095));
    r = $urandom_range(0, 99);
    if (r < 30) begin
      c.op = OP_ALLOC;
      r = $urandom_range(0, 99);
      if (r < 85) c.cnt = CountW'($urandom_range(1, 6));
      else if (r < 90) c.cnt = '0;
      if ($urandom_range(0, 4) != 0) c.tv = TypeW'($urandom_range(8, 15));
    end else if (r < 50) begin
      c.op = OP_FREE;
      if ($urandom_range(0, 19) != 0) c.idx = LinkW'(pick_head());
    end else if (r < 70) begin
      c.op = OP_MEASURE;
      if ($urandom_range(0, 19) != 0) c.idx = LinkW'(pick_head());
    end else if (r < 85) begin
      c.op = OP_READ;
      c.idx = LinkW'(pick_written());
    end else if (r < 96) begin
      // Links mostly point at written entries or end the chain.
      if ($urandom_range(0, 3) != 0)
        c.lv = ($urandom_range(0, 1) != 0) ? LinkW'(pick_written()) : '0;
    end else begin
      c.op = OpW'($urandom_range(5, 7));
    end
    if (board.touches_blank(c)) begin
      c.op = OP_WRITE;
      c.lv = '0;
    end
    return c;
  endfunction

  task automatic directed_items();
    send(mk(OP_READ, 0));
    send(mk(OP_WRITE, 4095, 0, 15, 0));
    send(mk(OP_READ, 4095));
    send(mk(OP_MEASURE, 4095));
    send(mk(OP_ALLOC, 0, 0, 8));
    send(mk(OP_ALLOC, 0, 3, 9));
    send(mk(OP_ALLOC, 0, 4095, 8));
    send(mk(OP_FREE, 0));
    send(mk(OP_MEASURE, 0));
    send(mk(5, 1)); send(mk(6, 2)); send(mk(7, 3));
    // A head with a low type is not a head.
    send(mk(OP_WRITE, 10, 0, 2, 0));
    send(mk(OP_MEASURE, 10));
    // A chain whose second slot carries the wrong type is broken.
    send(mk(OP_WRITE, 20, 0, 9, 21));
    send(mk(OP_WRITE, 21, 0, 15, 0));
    send(mk(OP_MEASURE, 20));
    // A two-slot cycle: measure sees the head come round again, free loops.
    send(mk(OP_WRITE, 30, 0, 9, 31));
    send(mk(OP_WRITE, 31, 0, 1, 30));
    send(mk(OP_MEASURE, 30));
    send(mk(OP_FREE, 30));
    // A one-slot free list hands out its only slot and is then empty.
    send(mk(OP_WRITE, 0, 0, 0, 4095));
    send(mk(OP_ALLOC, 0, 1, 8));
  endtask

  initial begin
    logic [TypeW-1:0] unused_set[5] = '{4'd0, 4'd15, 4'd7, 4'd0, 4'd10};
    logic [TypeW-1:0] cont_set[5]   = '{4'd1, 4'd14, 4'd0, 4'd15, 4'd8};
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    for (int ph = 0; ph < 5; ph++) begin
      steady = (ph == 2);
      write_cfg(CFG_UNUSED, unused_set[ph]);
      write_cfg(CFG_CONT, cont_set[ph]);
      cfg_valid <= 0;
      lay_free_list();
      if (ph == 0) begin
        directed_items();
        lay_free_list();
      end
      for (int i = 0; i < 80; i++) send(random_cmd());
      drain();
    end
    if (board.errors == 0)
      $display("tb_chunk_chain_table_manager_unit: clean");
    else
      $display("tb_chunk_chain_table_manager_unit: errors");
    $finish;
  end

endmodule

`default_nettype wire
